[rtl/obwvg_pkg.sv]
// Shared package for the oriented box wireframe vertex generator.
// Holds the fixed-point widths, payload types, rotation angle table and the
// edge/corner tables. No dependencies.
`default_nettype none

package obwvg_pkg;

	localparam int TRIG_BITS    = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int VERTS        = 24;
	localparam int CW           = 34;               // CORDIC datapath width
	localparam int TW           = TRIG_BITS + 2;    // rounded sin/cos width
	localparam int PW           = 17 + TW;          // offset times trig product
	localparam int SW           = PW + 1;           // sum of two products
	localparam int RW           = SW - (TRIG_BITS + 1); // rotated offset in 1/256 m
	localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
	localparam int VCNT_BITS    = $clog2(VERTS);
	localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

	typedef logic signed [CW-1:0] cw_t;
	typedef logic signed [TW-1:0] trig_t;
	typedef logic signed [23:0]   coord_t;
	typedef logic [15:0]          dim_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		dim_t   w;
		dim_t   h;
		dim_t   l;
		logic   flip;
	} box_t;

	// atan(2^-i), 2^32 per turn
	function automatic cw_t atan_val(input logic [STEP_BITS-1:0] i);
		logic [31:0] v;
		begin
			case (i)
				5'd0:  v = 32'h20000000;
				5'd1:  v = 32'h12E4051E;
				5'd2:  v = 32'h09FB385B;
				5'd3:  v = 32'h051111D4;
				5'd4:  v = 32'h028B0D43;
				5'd5:  v = 32'h0145D7E1;
				5'd6:  v = 32'h00A2F61E;
				5'd7:  v = 32'h00517C55;
				5'd8:  v = 32'h0028BE53;
				5'd9:  v = 32'h00145F2F;
				5'd10: v = 32'h000A2F98;
				5'd11: v = 32'h000517CC;
				5'd12: v = 32'h00028BE6;
				5'd13: v = 32'h000145F3;
				5'd14: v = 32'h0000A2FA;
				5'd15: v = 32'h0000517D;
				5'd16: v = 32'h000028BE;
				5'd17: v = 32'h0000145F;
				5'd18: v = 32'h00000A30;
				5'd19: v = 32'h00000518;
				5'd20: v = 32'h0000028C;
				5'd21: v = 32'h00000146;
				5'd22: v = 32'h000000A3;
				5'd23: v = 32'h00000051;
				5'd24: v = 32'h00000029;
				5'd25: v = 32'h00000014;
				5'd26: v = 32'h0000000A;
				5'd27: v = 32'h00000005;
				5'd28: v = 32'h00000003;
				5'd29: v = 32'h00000001;
				default: v = 32'h0;
			endcase
			atan_val = cw_t'({2'b00, v});
		end
	endfunction

	// corner of each vertex: FTR FTL FBL FBR BTR BTL BBL BBR = 0..7
	function automatic logic [2:0] edge_corner(input logic [VCNT_BITS-1:0] k);
		begin
			case (k)
				5'd0, 5'd7, 5'd8:          edge_corner = 3'd0;
				5'd1, 5'd2, 5'd11:         edge_corner = 3'd1;
				5'd3, 5'd4, 5'd12:         edge_corner = 3'd2;
				5'd5, 5'd6, 5'd15:         edge_corner = 3'd3;
				5'd9, 5'd17, 5'd18:        edge_corner = 3'd4;
				5'd10, 5'd19, 5'd20:       edge_corner = 3'd5;
				5'd13, 5'd21, 5'd22:       edge_corner = 3'd6;
				5'd14, 5'd16, 5'd23:       edge_corner = 3'd7;
				default:                   edge_corner = 3'd0;
			endcase
		end
	endfunction

	function automatic logic corner_pos_x(input logic [2:0] c);
		corner_pos_x = (c == 3'd0) || (c == 3'd3) || (c == 3'd4) || (c == 3'd7);
	endfunction

	function automatic logic corner_pos_y(input logic [2:0] c);
		corner_pos_y = (c == 3'd0) || (c == 3'd1) || (c == 3'd4) || (c == 3'd5);
	endfunction

	function automatic logic corner_pos_z(input logic [2:0] c);
		corner_pos_z = !c[2];
	endfunction

	function automatic logic [1:0] corner_color(input logic [2:0] c);
		begin
			case (c)
				3'd2, 3'd3: corner_color = 2'd1;
				3'd6, 3'd7: corner_color = 2'd2;
				default:    corner_color = 2'd0;
			endcase
		end
	endfunction

endpackage

`default_nettype wire

[rtl/obwvg_box_if.sv]
// Box input channel: valid/ready handshake with the box description.
// Depends on nothing.
`default_nettype none

interface obwvg_box_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] center_x;
	logic signed [23:0] center_y;
	logic signed [23:0] center_z;
	logic [15:0]        size_w;
	logic [15:0]        size_h;
	logic [15:0]        size_l;
	logic signed [15:0] heading;

	modport source (output valid, center_x, center_y, center_z, size_w, size_h, size_l,
		heading, input ready);
	modport sink (input valid, center_x, center_y, center_z, size_w, size_h, size_l,
		heading, output ready);
endinterface

`default_nettype wire

[rtl/obwvg_vert_if.sv]
// Vertex output channel: valid/ready handshake with one wireframe vertex.
// Depends on nothing.
`default_nettype none

interface obwvg_vert_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] vert_x;
	logic signed [23:0] vert_y;
	logic signed [23:0] vert_z;
	logic [1:0]         color_index;
	logic               last_vertex;

	modport source (output valid, vert_x, vert_y, vert_z, color_index, last_vertex,
		input ready);
	modport sink (input valid, vert_x, vert_y, vert_z, color_index, last_vertex,
		output ready);
endinterface

`default_nettype wire

[rtl/obwvg_cordic_cell.sv]
// One CORDIC rotation cell of the sine/cosine chain, carrying the box along.
// Depends on obwvg_pkg.
`default_nettype none

module obwvg_cordic_cell (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic [obwvg_pkg::STEP_BITS-1:0]    step,
	input  wire logic                               in_valid,
	input  wire obwvg_pkg::cw_t                     in_x,
	input  wire obwvg_pkg::cw_t                     in_y,
	input  wire obwvg_pkg::cw_t                     in_z,
	input  wire obwvg_pkg::box_t                    in_box,
	output logic                                    out_valid,
	output obwvg_pkg::cw_t                          out_x,
	output obwvg_pkg::cw_t                          out_y,
	output obwvg_pkg::cw_t                          out_z,
	output obwvg_pkg::box_t                         out_box
);

	obwvg_pkg::cw_t xs, ys, ang, nx, ny, nz;

	// rotate toward zero residual angle
	always_comb begin
		xs  = in_x >>> step;
		ys  = in_y >>> step;
		ang = obwvg_pkg::atan_val(step);
		if (!in_z[obwvg_pkg::CW-1]) begin
			nx = in_x - ys;
			ny = in_y + xs;
			nz = in_z - ang;
		end else begin
			nx = in_x + ys;
			ny = in_y - xs;
			nz = in_z + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	// hold while the chain is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			out_x   <= nx;
			out_y   <= ny;
			out_z   <= nz;
			out_box <= in_box;
		end
	end

endmodule

`default_nettype wire

[rtl/obwvg_vertex_emit.sv]
// Vertex emitter: walks the edge endpoints of a box in turn, rotates each
// corner offset and saturates. Depends on obwvg_pkg and obwvg_vert_if.
`default_nettype none

module obwvg_vertex_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire obwvg_pkg::box_t in_box,
	input  wire obwvg_pkg::trig_t in_c,
	input  wire obwvg_pkg::trig_t in_s,
	output logic                 in_take,
	obwvg_vert_if.source         vert_out
);

	localparam logic [obwvg_pkg::VCNT_BITS-1:0] LAST_K =
		obwvg_pkg::VCNT_BITS'(obwvg_pkg::VERTS - 1);

	obwvg_pkg::box_t  box_q;
	obwvg_pkg::trig_t c_q, s_q;
	logic             busy_q;
	logic [obwvg_pkg::VCNT_BITS-1:0] cnt_q;

	logic             ven;
	logic             issue;
	logic [2:0]       corner;
	logic signed [16:0] dx2, dy2;
	logic signed [17:0] zoff;

	logic                             valid_s1;
	logic signed [obwvg_pkg::PW-1:0]  pxc_s1, pys_s1, pyc_s1, pxs_s1;
	logic signed [24:0]               vz_s1;
	logic [1:0]                       col_s1;
	logic                             last_s1;
	obwvg_pkg::coord_t                cx_s1, cy_s1;

	logic signed [obwvg_pkg::SW-1:0]  rx, ry;
	logic signed [obwvg_pkg::RW-1:0]  ox, oy;
	logic signed [25:0]               sx, sy;

	function automatic obwvg_pkg::coord_t sat24(input logic signed [25:0] v);
		begin
			if (v > 26'sd8388607)
				sat24 = 24'sh7FFFFF;
			else if (v < -26'sd8388608)
				sat24 = 24'sh800000;
			else
				sat24 = v[23:0];
		end
	endfunction

	assign ven     = !vert_out.valid || vert_out.ready;
	assign issue   = busy_q && ven;
	assign in_take = in_valid && (!busy_q || (issue && cnt_q == LAST_K));

	// box hold and vertex counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (in_take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (issue) begin
			if (cnt_q == LAST_K) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			box_q <= in_box;
			c_q   <= in_c;
			s_q   <= in_s;
		end
	end

	// corner offsets: x and y in 1/512 m, z in 1/256 m
	always_comb begin
		corner = obwvg_pkg::edge_corner(cnt_q);
		dx2 = obwvg_pkg::corner_pos_x(corner) ? $signed({1'b0, box_q.w})
			: -$signed({1'b0, box_q.w});
		dy2 = obwvg_pkg::corner_pos_y(corner) ? $signed({1'b0, box_q.h})
			: -$signed({1'b0, box_q.h});
		zoff = obwvg_pkg::corner_pos_z(corner) ? $signed({2'b00, 16'((17'(box_q.l) + 17'd1) >> 1)})
			: -$signed({3'b000, box_q.l[15:1]});
	end

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ven) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ven) begin
			pxc_s1  <= dx2 * c_q;
			pys_s1  <= dy2 * s_q;
			pyc_s1  <= dy2 * c_q;
			pxs_s1  <= dx2 * s_q;
			vz_s1   <= 25'(box_q.cz) + 25'(zoff);
			col_s1  <= obwvg_pkg::corner_color(corner);
			last_s1 <= (cnt_q == LAST_K);
			cx_s1   <= box_q.cx;
			cy_s1   <= box_q.cy;
		end
	end

	// stage 2: sum, round half up, add centre
	always_comb begin
		rx = obwvg_pkg::SW'(pxc_s1) + obwvg_pkg::SW'(pys_s1)
			+ (obwvg_pkg::SW'(1) <<< obwvg_pkg::TRIG_BITS);
		ry = obwvg_pkg::SW'(pyc_s1) - obwvg_pkg::SW'(pxs_s1)
			+ (obwvg_pkg::SW'(1) <<< obwvg_pkg::TRIG_BITS);
		ox = rx[obwvg_pkg::SW-1:obwvg_pkg::TRIG_BITS+1];
		oy = ry[obwvg_pkg::SW-1:obwvg_pkg::TRIG_BITS+1];
		sx = 26'(cx_s1) + 26'(ox);
		sy = 26'(cy_s1) + 26'(oy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_out.valid <= 1'b0;
		end else if (ven) begin
			vert_out.valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ven) begin
			vert_out.vert_x      <= sat24(sx);
			vert_out.vert_y      <= sat24(sy);
			vert_out.vert_z      <= sat24(26'(vz_s1));
			vert_out.color_index <= col_s1;
			vert_out.last_vertex <= last_s1;
		end
	end

endmodule

`default_nettype wire

[rtl/oriented_box_wireframe_vertex_gen.sv]
// Top level: input angle fold, 30-cell CORDIC chain, trig rounding and the
// vertex emitter. Depends on obwvg_pkg, the channel interfaces and submodules.
`default_nettype none

// Takes one box (centre, extents, yaw) per transfer and returns 24 vertices,
// the endpoints of the 12 box edges, one vertex per cycle when the sink is
// ready: a box occupies the emitter for all 24 of its vertices, which sets
// the sustained rate. A new box enters the 30-cell CORDIC chain while the
// previous one is still being emitted, so boxes overlap and the chain latency
// to the first vertex is paid once. Sine and cosine carry TRIG_BITS fractional
// bits; coordinates saturate to the 24-bit range.
module oriented_box_wireframe_vertex_gen_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	obwvg_box_if.sink    box_in,
	obwvg_vert_if.source vert_out
);

	localparam int N = obwvg_pkg::CORDIC_STEPS;

	logic            v_c   [N+1];
	obwvg_pkg::cw_t  x_c   [N+1];
	obwvg_pkg::cw_t  y_c   [N+1];
	obwvg_pkg::cw_t  z_c   [N+1];
	obwvg_pkg::box_t box_c [N+1];

	logic            en;
	logic            take;
	logic [31:0]     ang;
	obwvg_pkg::cw_t  xr, yr, xf, yf;
	obwvg_pkg::trig_t cos_r, sin_r;

	function automatic obwvg_pkg::trig_t round_trig(input obwvg_pkg::cw_t v);
		obwvg_pkg::cw_t r;
		obwvg_pkg::cw_t lim;
		begin
			r   = (v + (obwvg_pkg::cw_t'(1) <<< (29 - obwvg_pkg::TRIG_BITS)))
				>>> (30 - obwvg_pkg::TRIG_BITS);
			lim = obwvg_pkg::cw_t'(1) <<< obwvg_pkg::TRIG_BITS;
			if (r > lim)
				r = lim;
			else if (r < -lim)
				r = -lim;
			round_trig = r[obwvg_pkg::TW-1:0];
		end
	endfunction

	// fold the left half plane by a half turn
	always_comb begin
		ang = {box_in.heading, 16'h0000};
		box_c[0].cx   = box_in.center_x;
		box_c[0].cy   = box_in.center_y;
		box_c[0].cz   = box_in.center_z;
		box_c[0].w    = box_in.size_w;
		box_c[0].h    = box_in.size_h;
		box_c[0].l    = box_in.size_l;
		box_c[0].flip = ang[31] ^ ang[30];
		if (ang[31] ^ ang[30]) begin
			ang[31] = ~ang[31];
		end
		v_c[0] = box_in.valid;
		x_c[0] = obwvg_pkg::cw_t'(obwvg_pkg::CORDIC_GAIN);
		y_c[0] = '0;
		z_c[0] = obwvg_pkg::cw_t'($signed(ang));
	end

	// advance the chain unless its last cell is blocked
	assign en           = !v_c[N] || take;
	assign box_in.ready = en;

	for (genvar i = 0; i < N; i++) begin : g_cell
		obwvg_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (obwvg_pkg::STEP_BITS'(i)),
			.in_valid  (v_c[i]),
			.in_x      (x_c[i]),
			.in_y      (y_c[i]),
			.in_z      (z_c[i]),
			.in_box    (box_c[i]),
			.out_valid (v_c[i+1]),
			.out_x     (x_c[i+1]),
			.out_y     (y_c[i+1]),
			.out_z     (z_c[i+1]),
			.out_box   (box_c[i+1])
		);
	end

	// undo the fold and round to the trig format
	always_comb begin
		xf    = box_c[N].flip ? -x_c[N] : x_c[N];
		yf    = box_c[N].flip ? -y_c[N] : y_c[N];
		xr    = xf;
		yr    = yf;
		cos_r = round_trig(xr);
		sin_r = round_trig(yr);
	end

	obwvg_vertex_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_c[N]),
		.in_box   (box_c[N]),
		.in_c     (cos_r),
		.in_s     (sin_r),
		.in_take  (take),
		.vert_out (vert_out)
	);

endmodule

`default_nettype wire

[tb/tb_obwvg_scoreboard.sv]
// Vertex scoreboard for the oriented box wireframe vertex generator testbench.
// Holds the box-to-vertex predictor and the queue of expected vertices; depends on nothing.
`timescale 1ns / 1ps

package tb_obwvg_sb_pkg;

	localparam int TRIG_FRAC = 16;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [1:0]         col;
		logic               last;
	} vertex_t;

	class vertex_scoreboard;
		vertex_t pending[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		static function longint floor_sh(longint v, int s);
			return v >>> s;
		endfunction

		static function longint clamp24(longint v);
			if (v > 64'sd8388607) return 64'sd8388607;
			if (v < -64'sd8388608) return -64'sd8388608;
			return v;
		endfunction

		static function longint atan_step(int i);
			longint t[30] = '{
				64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
				64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
				64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
				64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
				64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
				64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
			return t[i];
		endfunction

		static function longint trig_round(longint q);
			longint lim;
			longint r;
			lim = 64'sd1 << TRIG_FRAC;
			r = floor_sh(q + (64'sd1 << (29 - TRIG_FRAC)), 30 - TRIG_FRAC);
			if (r > lim) r = lim;
			if (r < -lim) r = -lim;
			return r;
		endfunction

		// CORDIC in rotation mode with a half-turn fold
		static function void yaw_sincos(logic [15:0] hd, output longint c, output longint s);
			logic [31:0] ang;
			bit          flip;
			longint      x, y, z, xs, ys;
			ang = {hd, 16'h0};
			flip = 0;
			x = 64'sd652032874;
			y = 0;
			if (ang >= 32'h40000000 && ang < 32'hC0000000) begin
				ang = ang - 32'h80000000;
				flip = 1;
			end
			z = ang >= 32'h80000000 ? longint'(ang) - (64'sd1 << 32) : longint'(ang);
			for (int i = 0; i < 30; i++) begin
				xs = floor_sh(x, i);
				ys = floor_sh(y, i);
				if (z >= 0) begin
					x -= ys; y += xs; z -= atan_step(i);
				end else begin
					x += ys; y -= xs; z += atan_step(i);
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			c = trig_round(x);
			s = trig_round(y);
		endfunction

		// note an accepted box: queue its 24 vertices
		function void note_box(logic signed [23:0] cx, logic signed [23:0] cy,
				logic signed [23:0] cz, logic [15:0] w, logic [15:0] h,
				logic [15:0] l, logic [15:0] hd);
			byte    seq[24] = '{0,1,1,2,2,3,3,0,0,4,5,1,2,6,7,3,7,4,4,5,5,6,6,7};
			int     sx[8] = '{1,-1,-1,1,1,-1,-1,1};
			int     sy[8] = '{1,1,-1,-1,1,1,-1,-1};
			int     sz[8] = '{1,1,1,1,-1,-1,-1,-1};
			int     cc[8] = '{0,0,1,1,0,0,2,2};
			longint c, s, dx, dy, rx, ry, hf;
			vertex_t v;
			int     cn;
			yaw_sincos(hd, c, s);
			hf = 64'sd1 << TRIG_FRAC;
			for (int k = 0; k < 24; k++) begin
				cn = seq[k];
				dx = sx[cn] * longint'(w);
				dy = sy[cn] * longint'(h);
				rx = dx * c + dy * s;
				ry = dy * c - dx * s;
				v.x = 24'(clamp24(longint'(cx) + floor_sh(rx + hf, TRIG_FRAC + 1)));
				v.y = 24'(clamp24(longint'(cy) + floor_sh(ry + hf, TRIG_FRAC + 1)));
				v.z = 24'(clamp24(longint'(cz) + floor_sh(sz[cn] * longint'(l) + 1, 1)));
				v.col = 2'(cc[cn]);
				v.last = (k == 23);
				pending.push_back(v);
			end
		endfunction

		// check one vertex transfer against the oldest expectation
		function void check_vertex(vertex_t a);
			vertex_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected vertex x=%0d y=%0d z=%0d", $time, a.x, a.y, a.z);
				return;
			end
			e = pending.pop_front();
			if (a.x !== e.x || a.y !== e.y || a.z !== e.z || a.col !== e.col
					|| a.last !== e.last) begin
				errors++;
				$display("%0t: expected x=%0d y=%0d z=%0d c=%0d l=%0d, got x=%0d y=%0d z=%0d c=%0d l=%0d",
					$time, e.x, e.y, e.z, e.col, e.last, a.x, a.y, a.z, a.col, a.last);
			end
		endfunction
	endclass

endpackage

[tb/tb_top.sv]
// Top of the vertex generator testbench: clock, reset, box driver and vertex monitor.
// Depends on obwvg_pkg, the channel interfaces and tb_obwvg_sb_pkg.
`timescale 1ns / 1ps

module tb_top;

	logic clk = 0;
	logic arst_n = 0;
	int   cycles = 0;
	bit   calm = 0;
	tb_obwvg_sb_pkg::vertex_scoreboard sb = new();

	obwvg_box_if  box_ch();
	obwvg_vert_if vert_ch();

	oriented_box_wireframe_vertex_gen_core dut (
		.clk(clk), .arst_n(arst_n), .box_in(box_ch.sink), .vert_out(vert_ch.source)
	);

	always #4 clk = ~clk;

	// hold off the sink at random, except in calm stretches
	initial vert_ch.ready = 0;
	always @(negedge clk) begin
		vert_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
	end

	// sample vertex transfers
	always @(posedge clk) begin
		tb_obwvg_sb_pkg::vertex_t v;
		cycles <= cycles + 1;
		if (arst_n && vert_ch.valid && vert_ch.ready) begin
			v.x = vert_ch.vert_x; v.y = vert_ch.vert_y; v.z = vert_ch.vert_z;
			v.col = vert_ch.color_index; v.last = vert_ch.last_vertex;
			sb.check_vertex(v);
		end
		if (cycles > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [23:0] pick24();
		case ($urandom_range(5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(2000) - 1000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(5))
			0: return 16'hFFFF;
			1: return 16'h0;
			default: return 16'($urandom);
		endcase
	endfunction

	// drive one box and wait for its transfer
	task automatic send_box(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz,
			logic [15:0] w, logic [15:0] h, logic [15:0] l, logic [15:0] hd);
		while (!calm && $urandom_range(99) < 16) begin
			box_ch.valid <= 0;
			@(negedge clk);
		end
		box_ch.valid <= 1;
		box_ch.center_x <= cx; box_ch.center_y <= cy; box_ch.center_z <= cz;
		box_ch.size_w <= w; box_ch.size_h <= h; box_ch.size_l <= l;
		box_ch.heading <= hd;
		do @(posedge clk); while (!box_ch.ready);
		sb.note_box(cx, cy, cz, w, h, l, hd);
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] angles[12] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
			16'h8001, 16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001, 16'h2000, 16'hFFFF};
		int wait_n;
		box_ch.valid = 0;
		box_ch.center_x = 0; box_ch.center_y = 0; box_ch.center_z = 0;
		box_ch.size_w = 0; box_ch.size_h = 0; box_ch.size_l = 0; box_ch.heading = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: quadrant boundaries, zero and full sizes, saturation corners
		foreach (angles[i])
			send_box(24'd1000, -24'sd2000, 24'd300, 16'd1234, 16'd567, 16'd891, angles[i]);
		send_box(0, 0, 0, 0, 0, 0, 16'h1234);
		send_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_box(24'h800000, 24'h800000, 24'h800000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_box(24'h7FFF00, 24'h800100, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'h2000);
		send_box(24'h800000, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'd0, 16'd1, 16'h6000);
		send_box(24'h555555, 24'hAAAAAA, 24'h000001, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF);
		send_box(24'hAAAAAA, 24'h555555, 24'hFFFFFF, 16'hAAAA, 16'h5555, 16'h7FFF, 16'h8000);
		// random boxes, with a calm stretch in the middle
		for (int n = 0; n < 410; n++) begin
			calm = (n >= 150 && n < 230);
			send_box(pick24(), pick24(), pick24(), pick16(), pick16(), pick16(),
				16'($urandom));
		end
		box_ch.valid <= 0;
		calm = 0;
		wait_n = 0;
		while (sb.pending.size() != 0 && wait_n < 200000) begin
			@(posedge clk);
			wait_n++;
		end
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
rtl/obwvg_pkg.sv
rtl/obwvg_box_if.sv
rtl/obwvg_vert_if.sv
rtl/obwvg_cordic_cell.sv
rtl/obwvg_vertex_emit.sv
rtl/oriented_box_wireframe_vertex_gen.sv
tb/tb_obwvg_scoreboard.sv
tb/tb_top.sv
